[design/rcom_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcom_pkg
// shared types and constants for the rc override servo mux
// ----------------------------------------------------------------------------
package rcom_pkg;

    localparam int NormOne = 16384;

    localparam logic [1:0] OP_EDGE = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;

    localparam logic [1:0] CH_STEER = 2'd0;
    localparam logic [1:0] CH_THR   = 2'd1;
    localparam logic [1:0] CH_OVR   = 2'd2;

    localparam logic [2:0] REG_MIN     = 3'd0;
    localparam logic [2:0] REG_MAX     = 3'd1;
    localparam logic [2:0] REG_CENTRE  = 3'd2;
    localparam logic [2:0] REG_THRESH  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_SPTS    = 3'd5;
    localparam logic [2:0] REG_TPTS    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SDIV,
        ST_TDIV,
        ST_SERVO,
        ST_OUT
    } state_t;

    // divider request
    typedef struct packed {
        logic        start;
        logic [31:0] num_mag;
        logic [16:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage
`default_nettype wire

[design/rcom_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcom_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rcom_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rcom_pkg::div_req_t req,
    output rcom_pkg::div_rsp_t     rsp
);
    import rcom_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num_mag;
            rem_next  = '0;
            den_next  = req.den_mag;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
`default_nettype wire

[design/rc_override_servo_mux.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_override_servo_mux
// rc receiver pulse measurement with override of controller commands
// ----------------------------------------------------------------------------
// channel   direction  handshake      content
// event     in         valid/ready    op, channel, level, time, commands
// result    out        valid/ready    servo bytes, norms, override flag
// config    in         cfg_we         cfg_index, cfg_data
//
// every event with no stall runs a load state, two passes of the shared
// divider (32 steps and a done strobe each, steering then throttle, also when
// override is off), a servo state and the result beat. servo bytes are
// shifts of products, no division. ready is low from the accepted beat until
// the result beat is taken. reset restores register defaults and clears state.
module rc_override_servo_mux (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [1:0]         channel,
    input  wire logic               level,
    input  wire logic [31:0]        time_us,
    input  wire logic signed [15:0] command_steering,
    input  wire logic signed [15:0] command_throttle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              steering_servo,
    output logic [7:0]              throttle_servo,
    output logic signed [15:0]      steering_norm,
    output logic signed [15:0]      throttle_norm,
    output logic                    override_on
);
    import rcom_pkg::*;

    logic [15:0] pmin_reg, pmax_reg, pcen_reg, thr_reg;
    logic [31:0] tmo_reg;
    logic [23:0] spts_reg, tpts_reg;

    logic [31:0] rise_reg [3];
    logic [15:0] spulse_reg, tpulse_reg;
    logic        ovr_reg;
    logic [15:0] hs_reg, ht_reg;
    logic [31:0] lct_reg;

    state_t      state_reg, state_next;
    logic signed [15:0] s_reg, t_reg;
    logic [7:0]  ssv_reg, tsv_reg;
    logic [31:0] time_us_q;

    div_req_t    dreq;
    div_rsp_t    drsp;

    rcom_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic        acc;
    logic [31:0] wid32;
    logic [15:0] wid;
    assign acc   = in_valid && in_ready;
    assign wid32 = time_us - rise_reg[channel];
    assign wid   = wid32[15:0];

    // numerators and denominators
    logic signed [17:0] sden, tden_hi, tden_lo;
    logic signed [33:0] snum, tnum;
    logic signed [17:0] tden;
    assign sden    = $signed({2'b0, pmax_reg}) - $signed({2'b0, pmin_reg});
    assign snum    = (34'sd16384 * 34'(sden))
                     - (34'sd32768 * (34'($signed({2'b0, spulse_reg}))
                                      - 34'($signed({2'b0, pmin_reg}))));
    assign tden_hi = $signed({2'b0, pmax_reg}) - $signed({2'b0, pcen_reg});
    assign tden_lo = $signed({2'b0, pcen_reg}) - $signed({2'b0, pmin_reg});
    assign tden    = (tpulse_reg >= pcen_reg) ? tden_hi : tden_lo;
    assign tnum    = 34'sd16384 * (34'($signed({2'b0, tpulse_reg}))
                                   - 34'($signed({2'b0, pcen_reg})));

    // abs of numerator fits 32 bits, den 17 bits
    function automatic logic [31:0] mag34(input logic signed [33:0] v);
        logic signed [33:0] a;
        begin
            a = v[33] ? -v : v;
            return a[31:0];
        end
    endfunction

    function automatic logic [16:0] mag18(input logic signed [17:0] v);
        logic signed [17:0] a;
        begin
            a = v[17] ? -v : v;
            return a[16:0];
        end
    endfunction

    // clamp a signed quotient magnitude
    function automatic logic signed [15:0] clampq(input logic neg, input logic [31:0] q);
        begin
            if (q >= 32'd16384)
                return neg ? -16'sd16384 : 16'sd16384;
            return neg ? -$signed({1'b0, q[14:0]}) : $signed({1'b0, q[14:0]});
        end
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [15:0] v);
        begin
            if (v > 16'sd16384)
                return 16'sd16384;
            if (v < -16'sd16384)
                return -16'sd16384;
            return v;
        end
    endfunction

    // servo byte: (c*16384 + sgn*n*span) / 16384 toward zero, saturated
    function automatic logic [7:0] servo(input logic signed [15:0] n,
                                         input logic [23:0] pts,
                                         input logic invert);
        logic signed [9:0]  mx, c, mn, span;
        logic signed [31:0] prod, tot;
        logic signed [31:0] q;
        begin
            mx   = $signed({2'b0, pts[23:16]});
            c    = $signed({2'b0, pts[15:8]});
            mn   = $signed({2'b0, pts[7:0]});
            span = (n > 16'sd0) ? (invert ? c - mn : mx - c) : (invert ? mx - c : c - mn);
            prod = 32'(n) * 32'(span);
            tot  = invert ? (32'(c) * 32'sd16384) - prod : (32'(c) * 32'sd16384) + prod;
            q    = tot[31] ? -((-tot) >>> 14) : (tot >>> 14);
            if (q < 32'sd0)
                return 8'd0;
            if (q > 32'sd255)
                return 8'd255;
            return q[7:0];
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (acc) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_SDIV;
            ST_SDIV:  if (drsp.done) state_next = ST_TDIV;
            ST_TDIV:  if (drsp.done) state_next = ST_SERVO;
            ST_SERVO: state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        out_valid    = (state_reg == ST_OUT);
        dreq.start   = 1'b0;
        dreq.num_mag = mag34(snum);
        dreq.den_mag = mag18(sden);
        case (state_reg)
            ST_LOAD:
            begin
                dreq.start = 1'b1;
            end
            ST_SDIV:
            begin
                dreq.start   = drsp.done;
                dreq.num_mag = mag34(tnum);
                dreq.den_mag = mag18(tden);
            end
            default:
            begin
                dreq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pmin_reg  <= 16'd1020;
            pmax_reg  <= 16'd1970;
            pcen_reg  <= 16'd1392;
            thr_reg   <= 16'd1500;
            tmo_reg   <= 32'd500000;
            spts_reg  <= 24'd9004095;
            tpts_reg  <= 24'd8673082;
            rise_reg[0] <= '0;
            rise_reg[1] <= '0;
            rise_reg[2] <= '0;
            spulse_reg <= '0;
            tpulse_reg <= '0;
            ovr_reg    <= 1'b0;
            hs_reg     <= '0;
            ht_reg     <= '0;
            lct_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN:     pmin_reg <= cfg_data[15:0];
                    REG_MAX:     pmax_reg <= cfg_data[15:0];
                    REG_CENTRE:  pcen_reg <= cfg_data[15:0];
                    REG_THRESH:  thr_reg  <= cfg_data[15:0];
                    REG_TIMEOUT: tmo_reg  <= cfg_data;
                    REG_SPTS:    spts_reg <= cfg_data[23:0];
                    REG_TPTS:    tpts_reg <= cfg_data[23:0];
                    default:     ;
                endcase
            end
            if (acc)
            begin
                if (op == OP_EDGE && channel <= CH_OVR && (channel == CH_OVR || ovr_reg))
                begin
                    if (level)
                        rise_reg[channel] <= time_us;
                    else if (channel == CH_STEER)
                        spulse_reg <= wid;
                    else if (channel == CH_THR)
                        tpulse_reg <= wid;
                    else
                        ovr_reg <= (wid >= thr_reg);
                end
                else if (op == OP_CMD)
                begin
                    hs_reg  <= command_steering;
                    ht_reg  <= command_throttle;
                    lct_reg <= time_us;
                end
            end
            // timeout check after the event update
            if (state_reg == ST_LOAD && !ovr_reg && ((time_us_q - lct_reg) > tmo_reg))
            begin
                hs_reg <= '0;
                ht_reg <= '0;
            end
        end
    end

    // event time, then results
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            time_us_q <= time_us;
        end
        if (state_reg == ST_SDIV && drsp.done)
        begin
            if (ovr_reg)
                s_reg <= (sden == 18'sd0) ? (snum == 34'sd0 ? 16'sd0 :
                         (snum[33] ? -16'sd16384 : 16'sd16384))
                         : clampq(snum[33] ^ sden[17], drsp.quo);
            else
                s_reg <= clamp16($signed(hs_reg));
        end
        if (state_reg == ST_TDIV && drsp.done)
        begin
            if (ovr_reg)
                t_reg <= (tden == 18'sd0) ? (tnum == 34'sd0 ? 16'sd0 :
                         (tnum[33] ? -16'sd16384 : 16'sd16384))
                         : clampq(tnum[33] ^ tden[17], drsp.quo);
            else
                t_reg <= clamp16($signed(ht_reg));
        end
        if (state_reg == ST_SERVO)
        begin
            ssv_reg <= servo(s_reg, spts_reg, 1'b1);
            tsv_reg <= servo(t_reg, tpts_reg, 1'b0);
        end
    end

    assign steering_servo = ssv_reg;
    assign throttle_servo = tsv_reg;
    assign steering_norm  = s_reg;
    assign throttle_norm  = t_reg;
    assign override_on    = ovr_reg;

endmodule
`default_nettype wire
